@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk once reset is released.
`define WOPA_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define WOPA_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/wopa_pkg.sv @@
package wopa_pkg;

  localparam int MAX_WAVES_DEF = 8;

  // Item function codes
  localparam logic [1:0] FN_AMP   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_BAD   = 2'd1;
  localparam logic [1:0] STS_ZWGHT = 2'd2;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NUM_WAVES  = 2'd0;
  localparam cfg_idx_t CFG_MAX_EVENTS = 2'd1;
  localparam cfg_idx_t CFG_USE_WEIGHT = 2'd2;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] amp_re;
    logic signed [31:0] amp_im;
    logic [31:0]        weight;
  } in_t;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [63:0] sum_re;
    logic signed [63:0] sum_im;
    logic [31:0]        event_count;
    logic [1:0]         status;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECIP,
    S_EVT,
    S_CMT,
    S_DRAIN,
    S_RD_ISS,
    S_RD_DAT,
    S_ABS,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_GO,
    S_DIV_WAIT
  } state_t;

endpackage

@@ rtl/core/wopa_ram.sv @@
module wopa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wopa_div.sv @@
module wopa_div #(
  parameter int NUM_W = 128,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  // Restoring division, one quotient bit a cycle; quotient shifts into num_r
  always_comb begin
    rem_sh   = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      cnt_nxt = CW'(NUM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub;
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

@@ rtl/core/weighted_outer_product_accumulator_unit.sv @@
// Complex outer-product accumulator. Amplitude items (func 0) build an event
// of num_waves amplitudes; the first one of an event runs a reciprocal
// division of its weight, which is skipped when the weight is zero. The final
// one of an event, unless it is dropped for a zero weight in weighted mode,
// also sweeps the accumulator memory through a read-modify-write pipeline,
// with one row fetch per row, and waits for it to drain. A read-out (func 1)
// emits n*n results; in weighted mode, unless the status is bad, each of the
// two parts of a result goes through the same divider. A clear (func 2)
// empties the accumulator and the event state. Results are single-cycle
// out_strobe pulses that cannot be held off and never come back to back;
// take each one as it comes. Write configuration only while busy is low.
`include "assert_macros.svh"

module weighted_outer_product_accumulator_unit #(
  parameter int MAX_WAVES = wopa_pkg::MAX_WAVES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  wopa_pkg::in_t      in_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  wopa_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_strobe,
  output wopa_pkg::out_t     out_item
);

  import wopa_pkg::*;

  localparam int SLOTS = MAX_WAVES * MAX_WAVES;
  localparam int WW    = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
  localparam int KW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW    = $clog2(MAX_WAVES + 1);
  localparam logic [127:0] RECIP_NUM = 128'h1_0000_0000;

  // Configuration
  logic [3:0]  num_waves_r;
  logic [31:0] max_events_r;
  logic        use_weight_r;

  // Control and event state
  state_t            state_r, state_nxt;
  logic [WW-1:0]     pos_r, pos_nxt;
  logic [31:0]       events_r, events_nxt;
  logic [63:0]       rsum_r, rsum_nxt;
  logic [31:0]       recip_r, recip_nxt;
  logic              zflag_r, zflag_nxt;
  logic [SLOTS-1:0]  vld_r;
  logic              vld_clr;
  logic [NW-1:0]     n_r, n_nxt;
  logic              commit_r, commit_nxt;
  logic [WW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic              fetch_r, fetch_nxt;
  logic              lat_r;
  logic [63:0]       amp_i_r;
  logic [1:0]        status_r, status_nxt;
  logic              scaled_r, scaled_nxt;
  logic              comp_r, comp_nxt;
  logic [63:0]       val_re_r, val_re_nxt, val_im_r, val_im_nxt;
  logic [63:0]       res_re_r, res_re_nxt;
  logic              neg_r, neg_nxt;
  logic [63:0]       mag_r, mag_nxt;
  logic [63:0]       prod_lo_r, prod_lo_nxt, prod_hi_r, prod_hi_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_t              out_r, out_nxt;

  // Memory ports
  logic          amp_we;
  logic [WW-1:0] amp_waddr, amp_raddr;
  logic [63:0]   amp_wdata, amp_rdata;
  logic [KW-1:0] acc_raddr;
  logic [127:0]  acc_rdata, acc_wdata;

  // Divider
  logic         div_go, div_done;
  logic [127:0] div_num, div_quo;
  logic [63:0]  div_den;

  // Helpers
  logic [NW-1:0] n_cur;
  logic [WW-1:0] nm1;
  logic [KW-1:0] key_ij;
  logic          accept;
  logic          limit_hit;
  logic          rd_last;
  logic [127:0]  rd_q;
  logic [63:0]   src_val;
  logic [95:0]   full_prod;
  logic [63:0]   q_sat;
  logic          iss_v;

  // Commit pipeline
  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [KW-1:0]     s1_k_r, s2_k_r, s3_k_r, s4_k_r;
  logic signed [63:0] pr1_r, pr2_r, pr3_r, pr4_r;
  logic [127:0]      acc2_r, acc3_r, acc4_r;
  logic signed [28:0] tre_r, tim_r;
  logic signed [61:0] wre_r, wim_r;
  logic signed [31:0] ri, ii, rj, ij;
  logic [127:0]      acc1_q;
  logic signed [64:0] sre, sim;
  logic signed [61:0] tre_ext, tim_ext, rcp_ext;
  logic signed [63:0] add_re, add_im;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      return a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign limit_hit = (max_events_r != '0) && (events_r >= max_events_r);
  assign nm1       = WW'(n_r - NW'(1));
  assign key_ij    = KW'(KW'(i_r) * KW'(MAX_WAVES) + KW'(j_r));
  assign rd_last   = (i_r == nm1) && (j_r == nm1);
  assign rd_q      = vld_r[key_ij] ? acc_rdata : '0;
  assign src_val   = comp_r ? val_im_r : val_re_r;
  assign full_prod = {prod_hi_r, 32'b0} + {32'b0, prod_lo_r};

  // Matrix size in use: zero acts as one, clamp above the array size
  always_comb begin
    if (num_waves_r == '0) begin
      n_cur = NW'(1);
    end else if ({1'b0, num_waves_r} > 5'(MAX_WAVES)) begin
      n_cur = NW'(MAX_WAVES);
    end else begin
      n_cur = NW'(num_waves_r);
    end
  end

  // Saturate the magnitude quotient back to signed 64 bits
  always_comb begin
    if (neg_r) begin
      q_sat = ((|div_quo[127:64]) || (div_quo[63:0] > SMIN)) ? SMIN : (64'd0 - div_quo[63:0]);
    end else begin
      q_sat = ((|div_quo[127:64]) || (div_quo[63:0] > SMAX)) ? SMAX : div_quo[63:0];
    end
  end

  // Divider shared by the weight reciprocal and the read-out scaling
  always_comb begin
    if (state_r == S_IDLE) begin
      div_num = RECIP_NUM;
      div_den = 64'(in_item.weight);
    end else begin
      div_num = {16'b0, full_prod, 16'b0};
      div_den = rsum_r;
    end
  end

  // Sequencer: next state, counters and memory addresses
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    events_nxt     = events_r;
    rsum_nxt       = rsum_r;
    recip_nxt      = recip_r;
    zflag_nxt      = zflag_r;
    vld_clr        = 1'b0;
    n_nxt          = n_r;
    commit_nxt     = commit_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    fetch_nxt      = fetch_r;
    status_nxt     = status_r;
    scaled_nxt     = scaled_r;
    comp_nxt       = comp_r;
    val_re_nxt     = val_re_r;
    val_im_nxt     = val_im_r;
    res_re_nxt     = res_re_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    prod_lo_nxt    = prod_lo_r;
    prod_hi_nxt    = prod_hi_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    amp_we         = 1'b0;
    amp_waddr      = pos_r;
    amp_wdata      = {in_item.amp_im, in_item.amp_re};
    amp_raddr      = j_r;
    acc_raddr      = key_ij;
    iss_v          = 1'b0;
    div_go         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.func)
            FN_AMP: begin
              if (!limit_hit) begin
                amp_we     = 1'b1;
                n_nxt      = n_cur;
                commit_nxt = ((NW+1)'(pos_r) + (NW+1)'(1)) >= (NW+1)'(n_cur);
                if (pos_r == '0) begin
                  if (in_item.weight == '0) begin
                    recip_nxt = '0;
                    state_nxt = S_EVT;
                  end else begin
                    div_go    = 1'b1;
                    state_nxt = S_RECIP;
                  end
                end else begin
                  state_nxt = S_EVT;
                end
              end
            end
            FN_READ: begin
              n_nxt = n_cur;
              if (events_r == '0 || (use_weight_r && rsum_r == '0)) begin
                status_nxt = STS_BAD;
                scaled_nxt = 1'b0;
              end else begin
                status_nxt = zflag_r ? STS_ZWGHT : STS_OK;
                scaled_nxt = use_weight_r;
              end
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = S_RD_ISS;
            end
            FN_CLEAR: begin
              vld_clr    = 1'b1;
              pos_nxt    = '0;
              events_nxt = '0;
              rsum_nxt   = '0;
              recip_nxt  = '0;
              zflag_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_RECIP: begin
        if (div_done) begin
          recip_nxt = (|div_quo[127:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
          state_nxt = S_EVT;
        end
      end

      S_EVT: begin
        if (!commit_r) begin
          pos_nxt   = pos_r + WW'(1);
          state_nxt = S_IDLE;
        end else if (use_weight_r && recip_r == '0) begin
          // drop the event, remember the zero weight
          zflag_nxt = 1'b1;
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt    = '0;
          events_nxt = (events_r != 32'hFFFF_FFFF) ? events_r + 32'd1 : events_r;
          if (use_weight_r) begin
            rsum_nxt = sat_add_u(rsum_r, recip_r);
          end
          i_nxt     = '0;
          j_nxt     = '0;
          fetch_nxt = 1'b1;
          state_nxt = S_CMT;
        end
      end

      S_CMT: begin
        if (fetch_r) begin
          // fetch the row amplitude, no entry issued this cycle
          amp_raddr = i_r;
          fetch_nxt = 1'b0;
        end else begin
          iss_v = 1'b1;
          if (j_r == nm1) begin
            j_nxt = '0;
            if (i_r == nm1) begin
              state_nxt = S_DRAIN;
            end else begin
              i_nxt     = i_r + WW'(1);
              fetch_nxt = 1'b1;
            end
          end else begin
            j_nxt = j_r + WW'(1);
          end
        end
      end

      S_DRAIN: begin
        if (!(s1_v_r || s2_v_r || s3_v_r || s4_v_r)) begin
          state_nxt = S_IDLE;
        end
      end

      S_RD_ISS: begin
        state_nxt = S_RD_DAT;
      end

      S_RD_DAT: begin
        val_re_nxt = rd_q[63:0];
        val_im_nxt = rd_q[127:64];
        comp_nxt   = 1'b0;
        if (scaled_r) begin
          state_nxt = S_ABS;
        end else begin
          out_strobe_nxt = 1'b1;
          out_nxt        = '{row: 3'(i_r), col: 3'(j_r), sum_re: rd_q[63:0],
                             sum_im: rd_q[127:64], event_count: events_r,
                             status: status_r, last: rd_last};
          state_nxt      = rd_last ? S_IDLE : S_RD_ISS;
          if (j_r == nm1) begin
            j_nxt = '0;
            i_nxt = i_r + WW'(1);
          end else begin
            j_nxt = j_r + WW'(1);
          end
        end
      end

      S_ABS: begin
        neg_nxt   = src_val[63];
        mag_nxt   = src_val[63] ? (64'd0 - src_val) : src_val;
        state_nxt = S_MUL_LO;
      end

      S_MUL_LO: begin
        prod_lo_nxt = 64'(mag_r[31:0]) * 64'(events_r);
        state_nxt   = S_MUL_HI;
      end

      S_MUL_HI: begin
        prod_hi_nxt = 64'(mag_r[63:32]) * 64'(events_r);
        state_nxt   = S_DIV_GO;
      end

      S_DIV_GO: begin
        div_go    = 1'b1;
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          if (!comp_r) begin
            res_re_nxt = q_sat;
            comp_nxt   = 1'b1;
            state_nxt  = S_ABS;
          end else begin
            out_strobe_nxt = 1'b1;
            out_nxt        = '{row: 3'(i_r), col: 3'(j_r), sum_re: res_re_r,
                               sum_im: q_sat, event_count: events_r,
                               status: status_r, last: rd_last};
            state_nxt      = rd_last ? S_IDLE : S_RD_ISS;
            if (j_r == nm1) begin
              j_nxt = '0;
              i_nxt = i_r + WW'(1);
            end else begin
              j_nxt = j_r + WW'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  function automatic logic [63:0] sat_add_u(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + 65'(b);
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_waves_r  <= 4'd1;
      max_events_r <= '0;
      use_weight_r <= 1'b0;
      pos_r        <= '0;
      events_r     <= '0;
      rsum_r       <= '0;
      recip_r      <= '0;
      zflag_r      <= 1'b0;
      fetch_r      <= 1'b0;
      lat_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      events_r     <= events_nxt;
      rsum_r       <= rsum_nxt;
      recip_r      <= recip_nxt;
      zflag_r      <= zflag_nxt;
      fetch_r      <= fetch_nxt;
      lat_r        <= (state_r == S_CMT) && fetch_r;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NUM_WAVES:  num_waves_r  <= cfg_data[3:0];
          CFG_MAX_EVENTS: max_events_r <= cfg_data;
          CFG_USE_WEIGHT: use_weight_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    n_r       <= n_nxt;
    commit_r  <= commit_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    status_r  <= status_nxt;
    scaled_r  <= scaled_nxt;
    comp_r    <= comp_nxt;
    val_re_r  <= val_re_nxt;
    val_im_r  <= val_im_nxt;
    res_re_r  <= res_re_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
    out_r     <= out_nxt;
    if (lat_r) begin
      amp_i_r <= amp_rdata;
    end
  end

  // Entry valid bits: an entry never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || vld_clr) begin
      vld_r <= '0;
    end else if (s4_v_r) begin
      vld_r[s4_k_r] <= 1'b1;
    end
  end

  // Commit pipeline. Entries within one event are distinct and the next
  // item waits for the drain, so no forwarding is needed.
  assign ri     = amp_i_r[31:0];
  assign ii     = amp_i_r[63:32];
  assign rj     = amp_rdata[31:0];
  assign ij     = amp_rdata[63:32];
  assign acc1_q = vld_r[s1_k_r] ? acc_rdata : '0;

  assign sre = 65'(pr1_r) + 65'(pr2_r);
  assign sim = 65'(pr3_r) - 65'(pr4_r);

  assign tre_ext = 62'(tre_r);
  assign tim_ext = 62'(tim_r);
  assign rcp_ext = 62'($signed({1'b0, recip_r}));

  assign add_re = use_weight_r ? 64'(wre_r >>> 16) : 64'(wre_r);
  assign add_im = use_weight_r ? 64'(wim_r >>> 16) : 64'(wim_r);
  assign acc_wdata = {sat_add(acc4_r[127:64], add_im), sat_add(acc4_r[63:0], add_re)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
    s1_k_r <= key_ij;
    s2_k_r <= s1_k_r;
    s3_k_r <= s2_k_r;
    s4_k_r <= s3_k_r;
    // stage 1: four partial products of amp_i * conj(amp_j)
    pr1_r  <= ri * rj;
    pr2_r  <= ii * ij;
    pr3_r  <= ii * rj;
    pr4_r  <= ri * ij;
    acc2_r <= acc1_q;
    // stage 2: sum and floor to Q24
    tre_r  <= sre[64:36];
    tim_r  <= sim[64:36];
    acc3_r <= acc2_r;
    // stage 3: apply the event reciprocal in weighted mode
    wre_r  <= use_weight_r ? tre_ext * rcp_ext : tre_ext;
    wim_r  <= use_weight_r ? tim_ext * rcp_ext : tim_ext;
    acc4_r <= acc3_r;
  end

  wopa_ram #(
    .WIDTH (64),
    .DEPTH (MAX_WAVES)
  ) u_amp_ram (
    .clk   (clk),
    .we    (amp_we),
    .waddr (amp_waddr),
    .wdata (amp_wdata),
    .raddr (amp_raddr),
    .rdata (amp_rdata)
  );

  wopa_ram #(
    .WIDTH (128),
    .DEPTH (SLOTS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s4_v_r),
    .waddr (s4_k_r),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  wopa_div #(
    .NUM_W (128),
    .DEN_W (64)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  `WOPA_CHK(a_pipe_idle, (state_r == S_IDLE) |-> !(s1_v_r || s2_v_r || s3_v_r || s4_v_r), "commit pipeline busy while idle")
  `WOPA_CHK(a_strobe_gap, out_strobe |=> !out_strobe, "results on consecutive cycles")
  `WOPA_CHK(a_clear, (accept && in_item.func == FN_CLEAR) |=> (events_r == '0 && vld_r == '0), "clear left state behind")
  `WOPA_CHK(a_out_busy, (out_strobe && !out_item.last) |-> busy, "read-out ended before last entry")
  `WOPA_CHK_ALWAYS(a_rst_idle, !rst_n |=> (!busy && !out_strobe), "not idle after reset")

endmodule
